[sv/otp_tlv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package otp_tlv_pkg;

	localparam int OTP_BYTES = 1024;
	localparam int OFS_W = $clog2(OTP_BYTES);

	localparam logic [7:0] MAGIC_BYTE = 8'h3C;
	localparam logic [7:0] MAX_TYPE = 8'd32;
	// The window holds the three bytes that come before the current one.
	localparam logic [1:0] WINDOW_FULL = 2'd3;

	localparam int DATA_W = 8;
	localparam int TYPE_W = 6;
	localparam int ELEN_W = 10;

	typedef enum logic [3:0] {
		MODE_DONE = 4'b0001,
		MODE_SCAN = 4'b0010,
		MODE_SKIP = 4'b0100,
		MODE_EMIT = 4'b1000
	} scan_mode_t;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_NOT_FOUND = 1'b1;

	typedef struct packed {
		logic              result_kind;
		logic [DATA_W-1:0] payload_byte;
		logic [ELEN_W-1:0] element_length;
		logic              last;
	} result_t;

endpackage

`default_nettype wire

[sv/otp_tlv_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface otp_tlv_byte_if;
	import otp_tlv_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] otp_byte;
	logic              first_byte;

	modport source (output valid, output otp_byte, output first_byte, input ready);
	modport sink (input valid, input otp_byte, input first_byte, output ready);
endinterface

interface otp_tlv_res_if;
	import otp_tlv_pkg::*;

	logic              valid;
	logic              ready;
	logic              result_kind;
	logic [DATA_W-1:0] payload_byte;
	logic [ELEN_W-1:0] element_length;
	logic              last;

	modport source (output valid, output result_kind, output payload_byte,
		output element_length, output last, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input element_length, input last, output ready);
endinterface

`default_nettype wire

[sv/otp_tlv_scan_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module otp_tlv_scan_core (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            beat,
	input  wire [otp_tlv_pkg::DATA_W-1:0]  otp_byte,
	input  wire                            first_byte,
	input  wire                            cfg_we,
	input  wire [otp_tlv_pkg::TYPE_W-1:0]  cfg_wdata,
	output logic                           res_valid,
	output otp_tlv_pkg::result_t           res
);
	import otp_tlv_pkg::*;

	logic [TYPE_W-1:0] wanted_type_q;
	logic [23:0]       window_q, window_d;
	logic [1:0]        fill_q, fill_d;
	logic [OFS_W-1:0]  ofs_q, ofs_d;
	scan_mode_t        mode_q, mode_d;
	logic [OFS_W-1:0]  rem_q, rem_d;
	logic [OFS_W-1:0]  found_q, found_d;

	logic [23:0]       window_c;
	logic [1:0]        fill_c;
	logic [OFS_W-1:0]  rem_c;
	logic [OFS_W-1:0]  found_c;
	scan_mode_t        mode_c;

	logic [7:0]        hdr_magic, hdr_type;
	logic [15:0]       hdr_len;
	logic [16:0]       ofs_m1;
	logic              hdr_ok;
	logic [OFS_W+ELEN_W-1:0] found_ext;

	always_comb begin
		hdr_magic = window_q[23:16];
		hdr_type  = window_q[15:8];
		hdr_len   = {otp_byte, window_q[7:0]};
	end

	always_comb begin
		// A restart clears the scan state before the byte is looked at.
		if (first_byte) begin
			ofs_d    = OFS_W'(OTP_BYTES - 1);
			mode_c   = MODE_SCAN;
			window_c = '0;
			fill_c   = '0;
			rem_c    = '0;
			found_c  = '0;
		end else begin
			ofs_d    = (ofs_q != '0) ? ofs_q - OFS_W'(1) : ofs_q;
			mode_c   = mode_q;
			window_c = window_q;
			fill_c   = fill_q;
			rem_c    = rem_q;
			found_c  = found_q;
		end

		// The header is only checked with a full window, which a restart never has,
		// so the held window can be decoded directly.
		ofs_m1 = 17'(ofs_d) - 17'd1;
		hdr_ok = (hdr_magic == MAGIC_BYTE) && (hdr_type >= 8'd1) &&
			(hdr_type <= MAX_TYPE) && (17'(hdr_len) <= ofs_m1);

		window_d  = window_c;
		fill_d    = fill_c;
		rem_d     = rem_c;
		found_d   = found_c;
		mode_d    = mode_c;
		res_valid = 1'b0;
		found_ext = {{ELEN_W{1'b0}}, found_c};
		res.result_kind    = KIND_PAYLOAD;
		res.payload_byte   = otp_byte;
		res.element_length = found_ext[ELEN_W-1:0];
		res.last           = 1'b0;

		if (!first_byte && mode_q == MODE_DONE) begin
			ofs_d = ofs_q;
		end else if (mode_c == MODE_EMIT) begin
			res_valid = 1'b1;
			res.last  = (rem_c <= OFS_W'(1));
			if (rem_c != '0)
				rem_d = rem_c - OFS_W'(1);
			if (res.last || ofs_d <= OFS_W'(1))
				mode_d = MODE_DONE;
		end else begin
			if (mode_c == MODE_SKIP) begin
				if (rem_c != '0)
					rem_d = rem_c - OFS_W'(1);
				if (rem_c <= OFS_W'(1)) begin
					mode_d   = MODE_SCAN;
					fill_d   = '0;
					window_d = '0;
				end
			end else if (fill_c == WINDOW_FULL && ofs_d >= OFS_W'(2)) begin
				if (hdr_ok) begin
					fill_d   = '0;
					window_d = '0;
					if (hdr_len != 16'd0) begin
						rem_d = hdr_len[OFS_W-1:0];
						if (hdr_type == {2'b00, wanted_type_q}) begin
							found_d = hdr_len[OFS_W-1:0];
							mode_d  = MODE_EMIT;
						end else begin
							mode_d = MODE_SKIP;
						end
					end
				end else begin
					window_d = {window_c[15:0], otp_byte};
				end
			end else begin
				window_d = {window_c[15:0], otp_byte};
				if (fill_c != WINDOW_FULL)
					fill_d = fill_c + 2'd1;
			end

			if (ofs_d <= OFS_W'(1) && mode_d != MODE_EMIT) begin
				mode_d             = MODE_DONE;
				res_valid          = 1'b1;
				res.result_kind    = KIND_NOT_FOUND;
				res.payload_byte   = '0;
				res.element_length = '0;
				res.last           = 1'b1;
			end
		end
		res_valid = res_valid & beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_type_q <= TYPE_W'(1);
			window_q      <= '0;
			fill_q        <= '0;
			ofs_q         <= '0;
			mode_q        <= MODE_DONE;
			rem_q         <= '0;
			found_q       <= '0;
		end else begin
			if (cfg_we)
				wanted_type_q <= cfg_wdata;
			if (beat) begin
				window_q <= window_d;
				fill_q   <= fill_d;
				ofs_q    <= ofs_d;
				mode_q   <= mode_d;
				rem_q    <= rem_d;
				found_q  <= found_d;
			end
		end
	end

endmodule

`default_nettype wire

[sv/otp_tlv_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module otp_tlv_out_reg (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        load,
	input  wire otp_tlv_pkg::result_t  res_in,
	output logic                       in_ready,
	otp_tlv_res_if.source              res_ch
);
	import otp_tlv_pkg::*;

	logic    valid_q;
	result_t data_q;

	// A new beat may enter while the held result is taken in the same cycle.
	assign in_ready = !valid_q || res_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && load)
			data_q <= res_in;
	end

	assign res_ch.valid          = valid_q;
	assign res_ch.result_kind    = data_q.result_kind;
	assign res_ch.payload_byte   = data_q.payload_byte;
	assign res_ch.element_length = data_q.element_length;
	assign res_ch.last           = data_q.last;

endmodule

`default_nettype wire

[sv/otp_tlv_element_scanner_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat carries
// in_ch     in         otp_byte, first_byte
// res_ch    out        result_kind, payload_byte, element_length, last
// cfg       in         wanted_type (write enable and data, no handshake)
//
// One byte is taken per cycle; its result, if any, appears in the output
// register on the next cycle. The output register is the only stall point:
// input is ready whenever that register is empty or being drained.
// Reset leaves the scanner idle until a beat with first_byte set arrives.

module otp_tlv_element_scanner_top (
	input  wire                           clk,
	input  wire                           arst_n,
	otp_tlv_byte_if.sink                  in_ch,
	otp_tlv_res_if.source                 res_ch,
	input  wire                           cfg_we,
	input  wire [otp_tlv_pkg::TYPE_W-1:0] cfg_wdata
);
	import otp_tlv_pkg::*;

	logic    in_ready;
	logic    beat;
	logic    res_valid;
	result_t res;

	assign in_ch.ready = in_ready;
	assign beat = in_ch.valid && in_ready;

	otp_tlv_scan_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (beat),
		.otp_byte   (in_ch.otp_byte),
		.first_byte (in_ch.first_byte),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.res_valid  (res_valid),
		.res        (res)
	);

	otp_tlv_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res_in   (res),
		.in_ready (in_ready),
		.res_ch   (res_ch)
	);

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import otp_tlv_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	// Offsets, counted downward, where the crafted headers near the bottom begin.
	localparam int TOO_LARGE_AT = 9;
	localparam int TAIL_FITS_AT = 5;
	localparam int TAIL_UNCHECKED_AT = 4;
	localparam int BODY_FLOOR = 40;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [TYPE_W-1:0] cfg_wdata;

	otp_tlv_byte_if in_ch ();
	otp_tlv_res_if res_ch ();

	otp_tlv_element_scanner_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.res_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Scanner mirror, advanced once per accepted input beat.
	logic [TYPE_W-1:0] p_wanted;
	logic [23:0]       p_window;
	logic [1:0]        p_fill;
	logic [15:0]       p_offset;
	scan_mode_t        p_mode;
	logic [15:0]       p_remaining;
	logic [15:0]       p_found;

	result_t    pending_results[$];
	logic [7:0] stream_bytes[$];
	int         errors;
	int         live_items;
	bit         src_idle;
	bit         sink_idle;
	int         sink_hold;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic predict_scan_byte(input logic [7:0] b, input logic f);
		logic [7:0]  magic;
		logic [7:0]  etype;
		logic [15:0] len;
		logic        fin;
		result_t     r;
		if (f) begin
			p_offset = 16'(OTP_BYTES - 1);
			p_mode = MODE_SCAN;
			p_window = '0;
			p_fill = '0;
			p_remaining = '0;
			p_found = '0;
		end else begin
			if (p_mode == MODE_DONE)
				return;
			if (p_offset > 0)
				p_offset = p_offset - 1;
		end

		if (p_mode == MODE_EMIT) begin
			fin = (p_remaining <= 1);
			r.result_kind = KIND_PAYLOAD;
			r.payload_byte = b;
			r.element_length = p_found[ELEN_W-1:0];
			r.last = fin;
			pending_results.push_back(r);
			if (p_remaining > 0)
				p_remaining = p_remaining - 1;
			if (fin || p_offset <= 1)
				p_mode = MODE_DONE;
			return;
		end

		if (p_mode == MODE_SKIP) begin
			if (p_remaining > 0)
				p_remaining = p_remaining - 1;
			if (p_remaining == 0) begin
				p_mode = MODE_SCAN;
				p_fill = '0;
				p_window = '0;
			end
		end else if (p_fill >= WINDOW_FULL && p_offset >= 2) begin
			magic = p_window[23:16];
			etype = p_window[15:8];
			len = {b, p_window[7:0]};
			if (magic == MAGIC_BYTE && etype >= 1 && etype <= MAX_TYPE &&
					len <= p_offset - 16'd1) begin
				p_fill = '0;
				p_window = '0;
				if (len != 0) begin
					p_remaining = len;
					if (etype == 8'(p_wanted)) begin
						p_found = len;
						p_mode = MODE_EMIT;
					end else begin
						p_mode = MODE_SKIP;
					end
				end
			end else begin
				p_window = {p_window[15:0], b};
			end
		end else begin
			p_window = {p_window[15:0], b};
			if (p_fill < WINDOW_FULL)
				p_fill = p_fill + 1;
		end

		if (p_offset <= 1 && p_mode != MODE_EMIT) begin
			p_mode = MODE_DONE;
			r.result_kind = KIND_NOT_FOUND;
			r.payload_byte = '0;
			r.element_length = '0;
			r.last = 1'b1;
			pending_results.push_back(r);
		end
	endtask

	// Called and returning at a falling edge; valid stays high between back-to-back beats.
	task automatic send_byte(input logic [7:0] b, input logic f);
		int gap;
		gap = src_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.otp_byte <= b;
		in_ch.first_byte <= f;
		do @(posedge clk); while (!in_ch.ready);
		if (f || p_mode != MODE_DONE)
			live_items++;
		predict_scan_byte(b, f);
		@(negedge clk);
	endtask

	// Bytes after the scan has finished would only be ignored, so the stream stops there.
	task automatic send_bytes();
		foreach (stream_bytes[i]) begin
			if (p_mode == MODE_DONE)
				break;
			send_byte(stream_bytes[i], 1'b0);
		end
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_results.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_wanted(input logic [TYPE_W-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		p_wanted = v;
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == MAGIC_BYTE);
		return b;
	endfunction

	function automatic logic [7:0] other_type();
		logic [7:0] t;
		do t = 8'($urandom_range(1, MAX_TYPE)); while (t == 8'(p_wanted));
		return t;
	endfunction

	task automatic build_element();
		logic [7:0]  etype;
		logic [15:0] len;
		int          sel;
		int          n;
		stream_bytes.delete();
		repeat ($urandom_range(0, 2))
			stream_bytes.push_back(8'($urandom_range(0, 255)));
		sel = $urandom_range(0, 9);
		if (sel < 6 && p_wanted >= 1 && p_wanted <= MAX_TYPE)
			etype = 8'(p_wanted);
		else if (sel < 9)
			etype = 8'($urandom_range(1, MAX_TYPE));
		else
			etype = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(33, 255));
		sel = $urandom_range(0, 19);
		if (sel < 2)
			len = '0;
		else if (sel < 16)
			len = 16'($urandom_range(1, 6));
		else if (sel < 18)
			len = 16'($urandom_range(7, 40));
		else if (sel == 18)
			len = {8'hFF, 8'($urandom_range(0, 255))};
		else
			len = 16'($urandom_range(0, 65535));
		stream_bytes.push_back(MAGIC_BYTE);
		stream_bytes.push_back(etype);
		stream_bytes.push_back(len[7:0]);
		stream_bytes.push_back(len[15:8]);
		// A header that claims a huge payload gets only a few bytes before the next one.
		n = (len > 40) ? 3 : int'(len);
		repeat (n)
			stream_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Runs a whole scan down to offset 1, with a too-large header and a final header
	// that begins at tail_at.
	task automatic scan_to_bottom(input int tail_at);
		int         n;
		logic [7:0] t;
		t = (p_wanted >= 1 && p_wanted <= MAX_TYPE) ? 8'(p_wanted) : 8'd1;
		send_byte(plain_byte(), 1'b1);
		while (p_mode != MODE_DONE) begin
			n = int'(p_offset) - 1;
			stream_bytes.delete();
			if (p_mode == MODE_SKIP) begin
				stream_bytes.push_back(8'($urandom_range(0, 255)));
			end else if (n == TOO_LARGE_AT) begin
				stream_bytes = {MAGIC_BYTE, t, 8'(n - 3), 8'd0};
			end else if (n == tail_at) begin
				stream_bytes = {MAGIC_BYTE, t, 8'd1, 8'd0};
			end else if (n >= BODY_FLOOR && $urandom_range(0, 3) == 0) begin
				stream_bytes = {MAGIC_BYTE, other_type(), 8'($urandom_range(0, 20)), 8'd0};
			end else begin
				stream_bytes.push_back(plain_byte());
			end
			send_bytes();
		end
		drain_results();
	endtask

	task automatic test_directed_headers();
		src_idle = 1'b1;
		sink_idle = 1'b1;
		// Nothing has started the scan yet, so these are dropped.
		send_byte(MAGIC_BYTE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		stream_bytes = {
			MAGIC_BYTE, 8'd33, 8'h01, 8'h00,
			MAGIC_BYTE, 8'd1, 8'h00, 8'h00,
			MAGIC_BYTE, 8'd5, 8'h01, 8'h00, 8'hAA,
			MAGIC_BYTE, 8'd1, 8'hFF, 8'hFF,
			MAGIC_BYTE, 8'd1, 8'h02, 8'h00, 8'hFF, 8'h00
		};
		send_bytes();
		drain_results();
	endtask

	task automatic test_type_limits();
		write_wanted(TYPE_W'(MAX_TYPE));
		send_byte(MAGIC_BYTE, 1'b1);
		stream_bytes = {8'd32, 8'h03, 8'h00, 8'h11};
		send_bytes();
		// A new first byte drops the element that is still being read out.
		send_byte(MAGIC_BYTE, 1'b1);
		stream_bytes = {8'd32, 8'h01, 8'h00, 8'h22};
		send_bytes();
		send_byte(8'h5A, 1'b0);
		drain_results();
	endtask

	task automatic test_output_backpressure();
		write_wanted(6'd7);
		src_idle = 1'b0;
		sink_idle = 1'b0;
		sink_hold = 60;
		send_byte(8'h00, 1'b1);
		stream_bytes = {MAGIC_BYTE, 8'd7, 8'd30, 8'd0};
		repeat (30)
			stream_bytes.push_back(8'($urandom_range(0, 255)));
		send_bytes();
		drain_results();
	endtask

	task automatic test_scan_max_length();
		write_wanted(6'd17);
		src_idle = 1'b1;
		sink_idle = 1'b0;
		// Header at the top address with the longest payload that still ends at offset 1.
		send_byte(MAGIC_BYTE, 1'b1);
		stream_bytes = {8'd17, 8'hFB, 8'h03};
		send_bytes();
		while (p_mode != MODE_DONE)
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		drain_results();
	endtask

	task automatic test_scan_bottom_fit();
		write_wanted(6'd9);
		src_idle = 1'b0;
		sink_idle = 1'b1;
		scan_to_bottom(TAIL_FITS_AT);
	endtask

	task automatic test_scan_not_found();
		write_wanted(6'd0);
		src_idle = 1'b1;
		sink_idle = 1'b1;
		scan_to_bottom(TAIL_UNCHECKED_AT);
	endtask

	task automatic test_random_scans();
		int scans;
		int start_items;
		int scan_start;
		int sel;
		scans = 0;
		start_items = live_items;
		while (live_items < start_items + 800) begin
			if (scans % 8 == 7) begin
				case ($urandom_range(0, 6))
					0: write_wanted(6'd1);
					1: write_wanted(TYPE_W'(MAX_TYPE));
					2: write_wanted(6'd0);
					3: write_wanted(6'd63);
					4: write_wanted(TYPE_W'($urandom_range(33, 62)));
					default: write_wanted(TYPE_W'($urandom_range(1, MAX_TYPE)));
				endcase
			end
			src_idle = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			send_byte(($urandom_range(0, 3) == 0) ? MAGIC_BYTE : 8'($urandom_range(0, 255)),
				1'b1);
			scan_start = live_items;
			while (p_mode != MODE_DONE && live_items - scan_start < 80) begin
				sel = $urandom_range(0, 9);
				if (sel < 7) begin
					build_element();
				end else if (sel < 9) begin
					stream_bytes.delete();
					repeat ($urandom_range(1, 4))
						stream_bytes.push_back(8'($urandom_range(0, 255)));
				end else begin
					stream_bytes.delete();
					send_byte(8'($urandom_range(0, 255)), 1'b1);
				end
				send_bytes();
			end
			scans++;
		end
	endtask

	initial begin : result_sink
		int      wait_left;
		result_t got;
		result_t want;
		wait_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				got.result_kind = res_ch.result_kind;
				got.payload_byte = res_ch.payload_byte;
				got.element_length = res_ch.element_length;
				got.last = res_ch.last;
				if (pending_results.size() == 0) begin
					if (errors < 10)
						$display("unexpected result beat: kind %0d byte %02h len %0d last %0d",
							got.result_kind, got.payload_byte, got.element_length, got.last);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						if (errors < 10)
							$display("mismatch: expected kind %0d byte %02h len %0d last %0d, %s",
								want.result_kind, want.payload_byte, want.element_length,
								want.last, $sformatf("got kind %0d byte %02h len %0d last %0d",
								got.result_kind, got.payload_byte, got.element_length, got.last));
						errors++;
					end
				end
				wait_left = sink_idle ? $urandom_range(0, 5) : 0;
			end
			@(negedge clk);
			if (sink_hold > 0) begin
				sink_hold--;
				res_ch.ready <= 1'b0;
			end else if (wait_left > 0) begin
				wait_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.otp_byte = '0;
		in_ch.first_byte = 1'b0;
		errors = 0;
		live_items = 0;
		src_idle = 1'b0;
		sink_idle = 1'b0;
		sink_hold = 0;
		p_wanted = 6'd1;
		p_window = '0;
		p_fill = '0;
		p_offset = '0;
		p_mode = MODE_DONE;
		p_remaining = '0;
		p_found = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_headers();
		test_type_limits();
		test_output_backpressure();
		test_scan_max_length();
		test_scan_bottom_fit();
		test_scan_not_found();
		test_random_scans();

		drain_results();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
sv/otp_tlv_pkg.sv
sv/otp_tlv_ifs.sv
sv/otp_tlv_scan_core.sv
sv/otp_tlv_out_reg.sv
sv/otp_tlv_element_scanner_top.sv
sim/tb_top.sv
